@@ sv/keypad_debounce_hold_scanner_defines.svh @@
// assertion macros for the keypad debounce and hold scanner
// no dependencies; included by the checker module
`ifndef KEYPAD_DEBOUNCE_HOLD_SCANNER_DEFINES_SVH
`define KEYPAD_DEBOUNCE_HOLD_SCANNER_DEFINES_SVH

// same-cycle implication
`define KDHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("keypad scanner assertion failed");

// next-cycle implication
`define KDHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keypad scanner assertion failed");

`endif

@@ sv/kdhs_pkg.sv @@
// shared types and constants for the keypad debounce and hold scanner
// no dependencies
package kdhs_pkg;

	localparam int unsigned NKEYS    = 16;
	localparam int unsigned KEY_W    = 4;
	localparam int unsigned CODE_W   = 4;
	localparam int unsigned DEB_W    = 8;
	localparam int unsigned HOLD_W   = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [KEY_W-1:0]  LAST_KEY = KEY_W'(NKEYS - 1);
	localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CODES    = 2'd2;

	localparam logic [DEB_W-1:0]      DEB_RESET   = 8'd3;
	localparam logic [HOLD_W-1:0]     HOLD_RESET  = 16'd10;
	localparam logic [CFG_DATA_W-1:0] CODES_RESET = '0;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_PRESS = 2'd1,
		EV_LONG  = 2'd2
	} ev_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic              seen;
		logic              pushed;
		logic              long_fired;
		logic [DEB_W-1:0]  deb;
		logic [HOLD_W-1:0] hold;
	} key_state_t;

	typedef struct packed {
		logic              pressed;
		logic [DEB_W-1:0]  ticks;
		logic [HOLD_W-1:0] threshold;
		key_state_t        cur;
	} key_req_t;

	typedef struct packed {
		key_state_t nxt;
		ev_kind_t   ev;
	} key_rsp_t;

endpackage

@@ sv/kdhs_key_unit.sv @@
// shared per-key update unit: debounce count, press and long-press decision
// depends on kdhs_pkg
module kdhs_key_unit (
	input  kdhs_pkg::key_req_t req,
	output kdhs_pkg::key_rsp_t rsp
);

	logic [kdhs_pkg::DEB_W-1:0]  deb_inc;
	logic [kdhs_pkg::HOLD_W-1:0] hold_inc;

	assign deb_inc  = req.cur.deb + kdhs_pkg::DEB_W'(1);
	assign hold_inc = (req.cur.hold == kdhs_pkg::HOLD_MAX) ? req.cur.hold
		: req.cur.hold + kdhs_pkg::HOLD_W'(1);

	always_comb begin
		rsp.nxt = req.cur;
		rsp.ev  = kdhs_pkg::EV_NONE;
		if (!req.pressed) begin
			rsp.nxt = '0;
		end else if (!req.cur.seen) begin
			rsp.nxt.seen = 1'b1;
		end else if (deb_inc != req.ticks) begin
			rsp.nxt.deb = deb_inc;
		end else begin
			rsp.nxt.deb = '0;
			if (!req.cur.pushed) begin
				rsp.nxt.pushed = 1'b1;
				rsp.nxt.hold   = '0;
				rsp.ev         = kdhs_pkg::EV_PRESS;
			end else begin
				rsp.nxt.hold = hold_inc;
				if (hold_inc > req.threshold && !req.cur.long_fired) begin
					rsp.nxt.long_fired = 1'b1;
					rsp.ev             = kdhs_pkg::EV_LONG;
				end
			end
		end
	end

endmodule

@@ sv/keypad_debounce_hold_scanner.sv @@
// keypad debounce and hold scanner top level: key state, sequencer, output register
// depends on kdhs_pkg and kdhs_key_unit
//
// usage:
//   scan channel (scan_valid/scan_ready/pressed_mask): one request is one full
//   scan of the key matrix. event channel (event_valid/event_ready and the
//   key_index, key_code, event_kind, last fields) gives one result per press or
//   long-press event found in the scan, in key order; last marks the final one.
//   a scan with no event gives a single result with event_kind 0 and last 1.
//   a scan request walks the keys one at a time through the shared update
//   unit, in index order, then places the final result. scan_ready is low
//   from accept until the final result is placed in the output register.
//   one event is held back so that last can be set; when the event_ready side
//   stalls and a further event must move out, the walk waits on that key.
//   cfg_we writes debounce_ticks (0), hold_threshold (1) or key_code_table (2)
//   in the cycle it is high; other indexes are dropped. write only while idle.
//   reset: all key state clears, registers return to 3, 10 and 0.
//   ROWS and COLS limit which matrix positions are scanned.
module keypad_debounce_hold_scanner #(
	parameter int unsigned ROWS = 4,
	parameter int unsigned COLS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [kdhs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kdhs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                scan_valid,
	output logic                                scan_ready,
	input  logic [kdhs_pkg::NKEYS-1:0]          pressed_mask,
	output logic                                event_valid,
	input  logic                                event_ready,
	output logic [kdhs_pkg::KEY_W-1:0]          key_index,
	output logic [kdhs_pkg::CODE_W-1:0]         key_code,
	output logic [1:0]                          event_kind,
	output logic                                last
);

	logic [kdhs_pkg::NKEYS-1:0] key_active;

	genvar gi;
	generate
		for (gi = 0; gi < kdhs_pkg::NKEYS; gi++) begin : g_active
			assign key_active[gi] = ((gi / 4) < ROWS) && ((gi % 4) < COLS);
		end
	endgenerate

	// configuration registers
	logic [kdhs_pkg::DEB_W-1:0]      deb_ticks_q;
	logic [kdhs_pkg::HOLD_W-1:0]     hold_thr_q;
	logic [kdhs_pkg::CFG_DATA_W-1:0] code_table_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_ticks_q  <= kdhs_pkg::DEB_RESET;
			hold_thr_q   <= kdhs_pkg::HOLD_RESET;
			code_table_q <= kdhs_pkg::CODES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				kdhs_pkg::CFG_DEBOUNCE: deb_ticks_q  <= cfg_data[kdhs_pkg::DEB_W-1:0];
				kdhs_pkg::CFG_HOLD:     hold_thr_q   <= cfg_data[kdhs_pkg::HOLD_W-1:0];
				kdhs_pkg::CFG_CODES:    code_table_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and key state
	kdhs_pkg::seq_state_t state_q, state_d;
	logic [kdhs_pkg::KEY_W-1:0]  key_q;
	logic [kdhs_pkg::NKEYS-1:0]  mask_q;
	logic [kdhs_pkg::NKEYS-1:0]  seen_q, pushed_q, long_q;
	logic [kdhs_pkg::DEB_W-1:0]  deb_q  [kdhs_pkg::NKEYS];
	logic [kdhs_pkg::HOLD_W-1:0] hold_q [kdhs_pkg::NKEYS];

	logic                       pend_valid_q;
	logic [kdhs_pkg::KEY_W-1:0] pend_idx_q;
	kdhs_pkg::ev_kind_t         pend_kind_q;

	logic                       ev_valid_q;
	logic [kdhs_pkg::KEY_W-1:0] ev_idx_q;
	logic [kdhs_pkg::CODE_W-1:0] ev_code_q;
	kdhs_pkg::ev_kind_t         ev_kind_q;
	logic                       ev_last_q;

	kdhs_pkg::key_req_t  unit_req;
	kdhs_pkg::key_rsp_t  unit_rsp;
	kdhs_pkg::ev_kind_t  walk_ev;

	logic scan_take, out_free, need_push, commit, load_walk, load_flush;

	always_comb begin
		unit_req.pressed        = mask_q[key_q];
		unit_req.ticks          = deb_ticks_q;
		unit_req.threshold      = hold_thr_q;
		unit_req.cur.seen       = seen_q[key_q];
		unit_req.cur.pushed     = pushed_q[key_q];
		unit_req.cur.long_fired = long_q[key_q];
		unit_req.cur.deb        = deb_q[key_q];
		unit_req.cur.hold       = hold_q[key_q];
	end

	kdhs_key_unit u_key_unit (
		.req (unit_req),
		.rsp (unit_rsp)
	);

	assign walk_ev   = key_active[key_q] ? unit_rsp.ev : kdhs_pkg::EV_NONE;
	assign out_free  = !ev_valid_q || event_ready;
	assign need_push = (walk_ev != kdhs_pkg::EV_NONE) && pend_valid_q;

	// control outputs
	always_comb begin
		scan_ready = 1'b0;
		commit     = 1'b0;
		load_walk  = 1'b0;
		load_flush = 1'b0;
		case (state_q)
			kdhs_pkg::ST_IDLE:  scan_ready = 1'b1;
			kdhs_pkg::ST_WALK: begin
				commit    = !need_push || out_free;
				load_walk = need_push && out_free;
			end
			kdhs_pkg::ST_FLUSH: load_flush = out_free;
			default: ;
		endcase
	end

	assign scan_take = scan_valid && scan_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kdhs_pkg::ST_IDLE:  if (scan_take) state_d = kdhs_pkg::ST_WALK;
			kdhs_pkg::ST_WALK:  if (commit && key_q == kdhs_pkg::LAST_KEY) state_d = kdhs_pkg::ST_FLUSH;
			kdhs_pkg::ST_FLUSH: if (load_flush) state_d = kdhs_pkg::ST_IDLE;
			default:            state_d = kdhs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= kdhs_pkg::ST_IDLE;
			key_q        <= '0;
			pend_valid_q <= 1'b0;
			seen_q       <= '0;
			pushed_q     <= '0;
			long_q       <= '0;
			for (int i = 0; i < kdhs_pkg::NKEYS; i++) begin
				deb_q[i]  <= '0;
				hold_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (scan_take) begin
				key_q        <= '0;
				pend_valid_q <= 1'b0;
			end
			if (commit) begin
				key_q <= key_q + kdhs_pkg::KEY_W'(1);
				if (key_active[key_q]) begin
					seen_q[key_q]   <= unit_rsp.nxt.seen;
					pushed_q[key_q] <= unit_rsp.nxt.pushed;
					long_q[key_q]   <= unit_rsp.nxt.long_fired;
					deb_q[key_q]    <= unit_rsp.nxt.deb;
					hold_q[key_q]   <= unit_rsp.nxt.hold;
				end
				if (walk_ev != kdhs_pkg::EV_NONE) begin
					pend_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_take) begin
			mask_q <= pressed_mask;
		end
		if (commit && walk_ev != kdhs_pkg::EV_NONE) begin
			pend_idx_q  <= key_q;
			pend_kind_q <= walk_ev;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (load_walk || load_flush) begin
			ev_valid_q <= 1'b1;
		end else if (event_ready) begin
			ev_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_walk || (load_flush && pend_valid_q)) begin
			ev_idx_q  <= pend_idx_q;
			ev_code_q <= code_table_q[{pend_idx_q, 2'b00} +: kdhs_pkg::CODE_W];
			ev_kind_q <= pend_kind_q;
			ev_last_q <= load_flush;
		end else if (load_flush) begin
			// empty scan
			ev_idx_q  <= '0;
			ev_code_q <= '0;
			ev_kind_q <= kdhs_pkg::EV_NONE;
			ev_last_q <= 1'b1;
		end
	end

	assign event_valid = ev_valid_q;
	assign key_index   = ev_idx_q;
	assign key_code    = ev_code_q;
	assign event_kind  = ev_kind_q;
	assign last        = ev_last_q;

endmodule

@@ sv/kdhs_checker.sv @@
// port-level checker for the keypad debounce and hold scanner, with its bind
// depends on kdhs_pkg and keypad_debounce_hold_scanner_defines.svh
`include "keypad_debounce_hold_scanner_defines.svh"

module kdhs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            scan_valid,
	input logic                            scan_ready,
	input logic                            event_valid,
	input logic                            event_ready,
	input logic [kdhs_pkg::KEY_W-1:0]      key_index,
	input logic [kdhs_pkg::CODE_W-1:0]     key_code,
	input logic [1:0]                      event_kind,
	input logic                            last
);

	// held result keeps its payload
	`KDHS_ASSERT_NXT(a_hold_payload, clk, arst_n, event_valid && !event_ready, event_valid && $stable({key_index, key_code, event_kind, last}))
	// a request keeps the block busy for the following cycle
	`KDHS_ASSERT_NXT(a_busy_after_take, clk, arst_n, scan_valid && scan_ready, !scan_ready)
	// an empty result is the only one of its scan
	`KDHS_ASSERT_IMP(a_empty_is_last, clk, arst_n, event_valid && event_kind == kdhs_pkg::EV_NONE, last && key_index == '0 && key_code == '0)
	// no undefined event code
	`KDHS_ASSERT_IMP(a_kind_legal, clk, arst_n, event_valid, event_kind != 2'd3)

endmodule

bind keypad_debounce_hold_scanner kdhs_checker u_kdhs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.scan_valid  (scan_valid),
	.scan_ready  (scan_ready),
	.event_valid (event_valid),
	.event_ready (event_ready),
	.key_index   (key_index),
	.key_code    (key_code),
	.event_kind  (event_kind),
	.last        (last)
);
